>>> hw/rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int DDO_CORDIC_STEPS = 16;
    localparam int DDO_ATAN_LEN     = 30;
    localparam int DDO_ATAN_IDX_W   = 5;
    localparam int DDO_CORDIC_W     = 33;
    localparam int DDO_PADDR_W      = 3;
    localparam int DDO_REG_IDX_W    = 1;

    localparam logic [DDO_CORDIC_W-1:0] DDO_CORDIC_START = 33'd652032874;

    localparam logic [19:0] DDO_CM_PER_TICK_RST      = 20'd1003;
    localparam logic [23:0] DDO_HEADING_PER_TICK_RST = 24'd701000;

    localparam logic [DDO_REG_IDX_W-1:0] REG_CM_PER_TICK      = 1'b0;
    localparam logic [DDO_REG_IDX_W-1:0] REG_HEADING_PER_TICK = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_ctl;

    typedef struct packed {
        logic        done;
        logic        c_neg;
        logic        s_neg;
        logic [31:0] c_abs;
        logic [31:0] s_abs;
    } t_cordic_res;

    function automatic logic [31:0] atan_entry(input logic [DDO_ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/ddo_in_if.sv
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;

    modport source (output valid, output left_delta, output right_delta, input ready);
    modport sink (input valid, input left_delta, input right_delta, output ready);
endinterface

>>> hw/rtl/ddo_out_if.sv
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

>>> hw/rtl/ddo_cordic.sv
module ddo_cordic import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = DDO_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_ctl i_ctl,
    output t_cordic_res o_res
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIN  = 3'b100
    } t_cstate;

    t_cstate r_state;
    logic [CNT_W-1:0] r_cnt;
    logic signed [DDO_CORDIC_W-1:0] r_x, r_y, r_z;
    logic r_flip;
    logic r_done;
    logic r_c_neg, r_s_neg;
    logic [31:0] r_c_abs, r_s_abs;

    logic w_flip;
    logic [31:0] w_angle;
    logic signed [DDO_CORDIC_W-1:0] w_xs, w_ys, w_at, w_cv, w_sv, w_ca, w_sa;

    always_comb begin
        w_flip  = i_ctl.angle[31] ^ i_ctl.angle[30];
        w_angle = {i_ctl.angle[31] ^ w_flip, i_ctl.angle[30:0]};
        w_xs    = r_x >>> r_cnt;
        w_ys    = r_y >>> r_cnt;
        w_at    = {1'b0, atan_entry(DDO_ATAN_IDX_W'(r_cnt))};
        w_cv    = r_flip ? -r_x : r_x;
        w_sv    = r_flip ? -r_y : r_y;
        w_ca    = w_cv[DDO_CORDIC_W-1] ? -w_cv : w_cv;
        w_sa    = w_sv[DDO_CORDIC_W-1] ? -w_sv : w_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (r_cnt == LAST) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_ctl.start) begin
            r_x    <= DDO_CORDIC_START;
            r_y    <= '0;
            r_z    <= {w_angle[31], w_angle};
            r_flip <= w_flip;
            r_cnt  <= '0;
        end else if (r_state == C_RUN) begin
            if (!r_z[DDO_CORDIC_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == C_FIN) begin
            r_c_neg <= w_cv[DDO_CORDIC_W-1];
            r_s_neg <= w_sv[DDO_CORDIC_W-1];
            r_c_abs <= w_ca[31:0];
            r_s_abs <= w_sa[31:0];
        end
    end

    assign o_res = '{done: r_done, c_neg: r_c_neg, s_neg: r_s_neg,
                     c_abs: r_c_abs, s_abs: r_s_abs};

endmodule

>>> hw/rtl/differential_drive_odometry.sv
// An accepted input transaction runs through the heading and distance multiplies, the CORDIC
// iterations and the x and y multiplies before the result is offered on the output; the
// single shared 24x32 multiplier is used six times per transaction.
// The input is not ready while a transaction is in progress.
// Synchronous active-low reset clears the pose to zero and loads the register defaults.
module differential_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = DDO_CORDIC_STEPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ddo_in_if.sink                 i_in,
    ddo_out_if.source              o_out,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [DDO_PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MTH   = 12'b000000000010,
        S_MD    = 12'b000000000100,
        S_CST   = 12'b000000001000,
        S_CWAIT = 12'b000000010000,
        S_MXL   = 12'b000000100000,
        S_MXH   = 12'b000001000000,
        S_MYL   = 12'b000010000000,
        S_MYH   = 12'b000100000000,
        S_YT    = 12'b001000000000,
        S_YS    = 12'b010000000000,
        S_PUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [19:0] r_cm_per_tick;
    logic [23:0] r_heading_per_tick;
    logic [31:0] r_heading, r_x, r_y, r_mid;
    logic [15:0] r_diff_abs;
    logic        r_diff_neg;
    logic [16:0] r_sum_abs;
    logic        r_sum_neg;
    logic [36:0] r_d2_abs;
    logic [55:0] r_prod;
    logic [32:0] r_q;
    logic [51:0] r_t;
    logic        r_out_valid;
    logic [31:0] r_out_x, r_out_y, r_out_h;

    logic [16:0] w_diff, w_sum, w_diff_abs, w_sum_abs;
    logic [32:0] w_dth;
    logic [23:0] w_ma;
    logic [31:0] w_mb;
    logic [55:0] w_prod;
    logic        w_accept, w_cfg_wr;
    t_cordic_ctl w_ctl;
    t_cordic_res w_res;

    function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [38:0] mag,
                                            input logic neg);
        logic [40:0] a, m, s;
        a = {{9{acc[31]}}, acc};
        m = {2'b00, mag};
        s = neg ? a - m : a + m;
        if (s[40:31] == {10{s[40]}}) begin
            return s[31:0];
        end else if (s[40]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    assign w_accept = i_in.valid && i_in.ready;
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_CM_PER_TICK:      prdata = {12'd0, r_cm_per_tick};
            REG_HEADING_PER_TICK: prdata = {8'd0, r_heading_per_tick};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        w_diff     = {i_in.right_delta[15], i_in.right_delta}
                   - {i_in.left_delta[15], i_in.left_delta};
        w_sum      = {i_in.right_delta[15], i_in.right_delta}
                   + {i_in.left_delta[15], i_in.left_delta};
        w_diff_abs = w_diff[16] ? -w_diff : w_diff;
        w_sum_abs  = w_sum[16] ? -w_sum : w_sum;
        w_dth      = r_diff_neg ? (~r_prod[32:0] + 33'd1) : r_prod[32:0];
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MTH: begin
                w_ma = r_heading_per_tick;
                w_mb = {16'd0, r_diff_abs};
            end
            S_MD: begin
                w_ma = {7'd0, r_sum_abs};
                w_mb = {12'd0, r_cm_per_tick};
            end
            S_MXL: begin
                w_ma = {6'd0, r_d2_abs[17:0]};
                w_mb = w_res.c_abs;
            end
            S_MXH: begin
                w_ma = {5'd0, r_d2_abs[36:18]};
                w_mb = w_res.c_abs;
            end
            S_MYL: begin
                w_ma = {6'd0, r_d2_abs[17:0]};
                w_mb = w_res.s_abs;
            end
            S_MYH: begin
                w_ma = {5'd0, r_d2_abs[36:18]};
                w_mb = w_res.s_abs;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {24'd0, w_mb};

    assign w_ctl = '{start: (r_state == S_CST), angle: r_mid};

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_res   (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MTH;
            S_MTH:   n_state = S_MD;
            S_MD:    n_state = S_CST;
            S_CST:   n_state = S_CWAIT;
            S_CWAIT: if (w_res.done) n_state = S_MXL;
            S_MXL:   n_state = S_MXH;
            S_MXH:   n_state = S_MYL;
            S_MYL:   n_state = S_MYH;
            S_MYH:   n_state = S_YT;
            S_YT:    n_state = S_YS;
            S_YS:    n_state = S_PUT;
            S_PUT:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_cm_per_tick      <= DDO_CM_PER_TICK_RST;
            r_heading_per_tick <= DDO_HEADING_PER_TICK_RST;
            r_heading          <= '0;
            r_x                <= '0;
            r_y                <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_CM_PER_TICK:      r_cm_per_tick <= pwdata[19:0];
                    REG_HEADING_PER_TICK: r_heading_per_tick <= pwdata[23:0];
                    default:              ;
                endcase
            end
            if (r_state == S_MD) begin
                r_heading <= r_heading + w_dth[31:0];
            end
            if (r_state == S_MYH) begin
                r_x <= sat_add(r_x, r_t[51:13], r_sum_neg ^ w_res.c_neg);
            end
            if (r_state == S_YS) begin
                r_y <= sat_add(r_y, r_t[51:13], r_sum_neg ^ w_res.s_neg);
            end
            if (r_state == S_PUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_accept) begin
            r_diff_abs <= w_diff_abs[15:0];
            r_diff_neg <= w_diff[16];
            r_sum_abs  <= w_sum_abs;
            r_sum_neg  <= w_sum[16];
        end
        if (r_state == S_MD) begin
            r_mid <= r_heading + w_dth[32:1];
        end
        if (r_state == S_CST) begin
            r_d2_abs <= r_prod[36:0];
        end
        if (r_state == S_MXH || r_state == S_MYH) begin
            r_q <= r_prod[50:18];
        end
        if (r_state == S_MYL || r_state == S_YT) begin
            r_t <= {1'b0, r_prod[50:0]} + {19'd0, r_q};
        end
        if (r_state == S_PUT && (!r_out_valid || o_out.ready)) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
            r_out_h <= r_heading;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_out_x;
    assign o_out.pos_y   = r_out_y;
    assign o_out.heading = r_out_h;

endmodule
